### sv/sigact_pkg.sv
`default_nettype none

package sigact_pkg;

   // cache geometry
   localparam int DEPTH   = 1024;
   localparam int INDEX_W = 10;

   // data widths
   localparam int VALUE_W = 16;
   localparam int ACT_W   = 16;

   // sample table
   localparam int TABLE_ENTRIES = 256;
   localparam int SEG_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int PROD_W        = VALUE_W + SEG_W;

   // cache word: valid mark on top of the stored activation
   localparam int WORD_W = ACT_W + 1;

   typedef enum logic {
      CMD_FWD = 1'b0,
      CMD_BWD = 1'b1
   } cmd_type;

endpackage

`default_nettype wire

### sv/sigmoid_activation_fwd_bwd_top.sv
`default_nettype none

// Element-wise sigmoid unit with a derivative path and a per-element cache.
// Input channel: req_command, req_index, req_value are taken at a rising edge
// with start high and busy low. A forward command returns y = sigmoid(x) on
// rsp_activation (unsigned Q0.16) and stores y in the cache at req_index. A
// backward command returns g*y*(1-y) on rsp_gradient (signed Q4.12) from the
// cached y; a never-written entry returns zero with rsp_error set.
// Result channel: rsp_valid strobes for one cycle with the result fields; the
// receiver takes every result and cannot stall the unit.
// Throughput: one item per clock while busy is low. Each item passes the
// stage 1, 2 and 3 registers and the result register, and the result is
// taken at the edge that ends the cycle in which rsp_valid is high. The cache
// is one 1024 x 17 synchronous RAM, read at acceptance and written from
// stage 2; a backward item that reaches stage 1 while a forward item to the
// same index is in stage 2 or 3 takes y by forwarding from the pipeline.
// Reset: after reset is released the unit sweeps the cache, one entry per
// clock, clearing every valid mark; busy stays high until the sweep ends
// and no item is taken meanwhile.
module sigmoid_activation_fwd_bwd_top (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output      logic                                     busy,
   input  wire logic                                     req_command,
   input  wire logic        [sigact_pkg::INDEX_W-1:0]    req_index,
   input  wire logic signed [sigact_pkg::VALUE_W-1:0]    req_value,
   output      logic                                     rsp_valid,
   output      logic        [sigact_pkg::ACT_W-1:0]      rsp_activation,
   output      logic signed [sigact_pkg::VALUE_W-1:0]    rsp_gradient,
   output      logic                                     rsp_error
);

   localparam int IW = sigact_pkg::INDEX_W;
   localparam int VW = sigact_pkg::VALUE_W;
   localparam int AW = sigact_pkg::ACT_W;
   localparam int SW = sigact_pkg::SEG_W;
   localparam int PW = sigact_pkg::PROD_W;
   localparam int WW = sigact_pkg::WORD_W;
   localparam int TE = sigact_pkg::TABLE_ENTRIES;

   // ---------------------------------------------------------------------
   // Sample table, built at elaboration
   // ---------------------------------------------------------------------
   logic [AW-1:0] sig_rom [TE+1];

   for (genvar k = 0; k <= TE; k++) begin : g_tbl
      localparam logic [63:0] T   = 64'(TE);
      localparam logic [63:0] TW  = 64'(2 * k);
      localparam logic [63:0] D   = (TW >= T) ? (TW - T) : (T - TW);
      localparam logic [63:0] G   = (D << 30) / T;
      localparam logic [63:0] ONE = 64'h8000_0000;
      localparam logic [63:0] R1  = ((ONE * G) >> 31) / 1;
      localparam logic [63:0] R2  = ((R1 * G) >> 31) / 2;
      localparam logic [63:0] R3  = ((R2 * G) >> 31) / 3;
      localparam logic [63:0] R4  = ((R3 * G) >> 31) / 4;
      localparam logic [63:0] R5  = ((R4 * G) >> 31) / 5;
      localparam logic [63:0] R6  = ((R5 * G) >> 31) / 6;
      localparam logic [63:0] R7  = ((R6 * G) >> 31) / 7;
      localparam logic [63:0] R8  = ((R7 * G) >> 31) / 8;
      localparam logic [63:0] R9  = ((R8 * G) >> 31) / 9;
      localparam logic [63:0] R10 = ((R9 * G) >> 31) / 10;
      localparam logic [63:0] R11 = ((R10 * G) >> 31) / 11;
      localparam logic [63:0] R12 = ((R11 * G) >> 31) / 12;
      localparam logic [63:0] SUM = ONE - R1 + R2 - R3 + R4 - R5 + R6
                                    - R7 + R8 - R9 + R10 - R11 + R12;
      localparam logic [63:0] E0  = (SUM > ONE) ? ONE : SUM;
      localparam logic [63:0] E1  = (E0 * E0 + 64'h4000_0000) >> 31;
      localparam logic [63:0] E2  = (E1 * E1 + 64'h4000_0000) >> 31;
      localparam logic [63:0] E3  = (E2 * E2 + 64'h4000_0000) >> 31;
      localparam logic [63:0] E4  = (E3 * E3 + 64'h4000_0000) >> 31;
      localparam logic [63:0] DEN = ONE + E4;
      localparam logic [63:0] NUM = (TW >= T) ? ONE : E4;
      localparam logic [63:0] YQ  = (NUM * 64'd65536 + DEN / 2) / DEN;
      localparam logic [63:0] TP  = (YQ > 64'd65535) ? 64'd65535 : YQ;
      assign sig_rom[k] = TP[AW-1:0];
   end

   // ---------------------------------------------------------------------
   // Clearing pass and handshake
   // ---------------------------------------------------------------------
   logic          clear_active_ff;
   logic [IW-1:0] clear_cnt_ff;
   logic          accept;

   assign busy   = clear_active_ff;
   assign accept = start && !clear_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_cnt_ff    <= '0;
      end else if (clear_active_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == IW'(sigact_pkg::DEPTH - 1)) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: table lookup, cache read
   // ---------------------------------------------------------------------
   logic [VW-1:0] raw0;
   logic [VW-1:0] u0;
   logic [PW-1:0] p0;
   logic [SW-1:0] seg_raw0;
   logic [SW-1:0] seg0;
   logic [SW-1:0] seg_next0;

   assign raw0      = req_value;
   assign u0        = raw0 ^ {1'b1, {(VW-1){1'b0}}};
   assign p0        = PW'(u0) * PW'(TE);
   assign seg_raw0  = p0[PW-1:16];
   assign seg0      = (seg_raw0 >= SW'(TE)) ? SW'(TE - 1) : seg_raw0;
   assign seg_next0 = seg0 + 1'b1;

   logic [WW-1:0] cache_mem [sigact_pkg::DEPTH];
   logic [WW-1:0] rd_word_ff;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [WW-1:0] wr_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cache_mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff <= cache_mem[req_index];
   end

   // ---------------------------------------------------------------------
   // Stage 1 registers
   // ---------------------------------------------------------------------
   logic                s1_valid_ff;
   sigact_pkg::cmd_type s1_cmd_ff;
   logic [IW-1:0]       s1_index_ff;
   logic [VW-1:0]       s1_value_ff;
   logic                s1_zero_ff;
   logic [AW-1:0]       s1_ta_ff;
   logic [AW-1:0]       s1_tb_ff;
   logic [15:0]         s1_frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= sigact_pkg::cmd_type'(req_command);
      s1_index_ff <= req_index;
      s1_value_ff <= raw0;
      s1_zero_ff  <= (u0 == '0);
      s1_ta_ff    <= sig_rom[seg0];
      s1_tb_ff    <= sig_rom[seg_next0];
      s1_frac_ff  <= p0[15:0];
   end

   // ---------------------------------------------------------------------
   // Stage 2 / 3 declarations (needed by forwarding)
   // ---------------------------------------------------------------------
   logic                s2_valid_ff;
   sigact_pkg::cmd_type s2_cmd_ff;
   logic [IW-1:0]       s2_index_ff;
   logic                s2_zero_ff;
   logic [32:0]         s2_sum_ff;
   logic [30:0]         s2_yv_ff;
   logic [VW-1:0]       s2_mag_ff;
   logic                s2_neg_ff;
   logic                s2_err_ff;
   logic [AW-1:0]       s2_y;

   logic                s3_valid_ff;
   sigact_pkg::cmd_type s3_cmd_ff;
   logic [IW-1:0]       s3_index_ff;
   logic [AW-1:0]       s3_y_ff;
   logic [46:0]         s3_prod_ff;
   logic                s3_neg_ff;
   logic                s3_err_ff;

   // ---------------------------------------------------------------------
   // Stage 1: interpolation products, cached y with forwarding
   // ---------------------------------------------------------------------
   logic [32:0]   s2_sum_in;
   logic          hit2;
   logic          hit3;
   logic [AW-1:0] y1;
   logic          ok1;
   logic [32:0]   yv1;
   logic [VW-1:0] mag_in;

   assign s2_sum_in = 33'(s1_ta_ff) * 33'(17'h1_0000 - {1'b0, s1_frac_ff})
                    + 33'(s1_tb_ff) * 33'(s1_frac_ff)
                    + 33'h0_0000_8000;

   assign hit2 = s2_valid_ff && (s2_cmd_ff == sigact_pkg::CMD_FWD)
              && (s2_index_ff == s1_index_ff);
   assign hit3 = s3_valid_ff && (s3_cmd_ff == sigact_pkg::CMD_FWD)
              && (s3_index_ff == s1_index_ff);

   // youngest forward write wins
   always_comb begin
      priority if (hit2) begin
         y1  = s2_y;
         ok1 = 1'b1;
      end else if (hit3) begin
         y1  = s3_y_ff;
         ok1 = 1'b1;
      end else begin
         y1  = rd_word_ff[AW-1:0];
         ok1 = rd_word_ff[WW-1];
      end
   end

   assign yv1    = 33'(y1) * 33'(17'h1_0000 - {1'b0, y1});
   assign mag_in = s1_value_ff[VW-1] ? VW'(17'h1_0000 - {1'b0, s1_value_ff})
                                     : s1_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_cmd_ff   <= s1_cmd_ff;
      s2_index_ff <= s1_index_ff;
      s2_zero_ff  <= s1_zero_ff;
      s2_sum_ff   <= s2_sum_in;
      s2_yv_ff    <= yv1[30:0];
      s2_mag_ff   <= mag_in;
      s2_neg_ff   <= s1_value_ff[VW-1];
      s2_err_ff   <= !ok1;
   end

   // ---------------------------------------------------------------------
   // Stage 2: finish y and write it back, gradient product
   // ---------------------------------------------------------------------
   logic [46:0] s3_prod_in;

   always_comb begin
      if (s2_zero_ff) begin
         s2_y = '0;
      end else if (s2_sum_ff[32]) begin
         s2_y = '1;
      end else begin
         s2_y = s2_sum_ff[31:16];
      end
   end

   assign s3_prod_in = 47'(s2_mag_ff) * 47'(s2_yv_ff);

   assign wr_en   = clear_active_ff || (s2_valid_ff && (s2_cmd_ff == sigact_pkg::CMD_FWD));
   assign wr_addr = clear_active_ff ? clear_cnt_ff : s2_index_ff;
   assign wr_word = clear_active_ff ? '0 : {1'b1, s2_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_cmd_ff   <= s2_cmd_ff;
      s3_index_ff <= s2_index_ff;
      s3_y_ff     <= s2_y;
      s3_prod_ff  <= s3_prod_in;
      s3_neg_ff   <= s2_neg_ff;
      s3_err_ff   <= s2_err_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 3: round, sign, result register
   // ---------------------------------------------------------------------
   logic [47:0]   rnd3;
   logic [VW-1:0] mag3;
   logic [VW-1:0] grad3;
   logic          fwd3;

   assign rnd3  = 48'(s3_prod_ff) + 48'h0000_8000_0000;
   assign mag3  = rnd3[47:32];
   assign grad3 = s3_neg_ff ? VW'(17'h1_0000 - {1'b0, mag3}) : mag3;
   assign fwd3  = (s3_cmd_ff == sigact_pkg::CMD_FWD);

   logic          rsp_valid_ff;
   logic [AW-1:0] rsp_activation_ff;
   logic [VW-1:0] rsp_gradient_ff;
   logic          rsp_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_activation_ff <= fwd3 ? s3_y_ff : '0;
      rsp_gradient_ff   <= (!fwd3 && !s3_err_ff) ? grad3 : '0;
      rsp_error_ff      <= !fwd3 && s3_err_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_activation = rsp_activation_ff;
   assign rsp_gradient   = rsp_gradient_ff;
   assign rsp_error      = rsp_error_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid_ff)
      else $error("transfer accepted without a result four cycles later");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> (rsp_activation_ff == '0 && rsp_gradient_ff == '0))
      else $error("error result carries nonzero data");

   a_clear_empty : assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff))
      else $error("item in flight during cache clear");

   a_fwd_no_err : assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_cmd_ff == sigact_pkg::CMD_FWD) |=> !rsp_error_ff)
      else $error("forward result flagged as error");

endmodule

`default_nettype wire

### bench/sigmoid_activation_fwd_bwd_top_tb.sv
`timescale 1ns / 100ps

module sigmoid_activation_fwd_bwd_top_tb;

   localparam int ACT_W         = sigact_pkg::ACT_W;
   localparam int VALUE_W       = sigact_pkg::VALUE_W;
   localparam int INDEX_W       = sigact_pkg::INDEX_W;
   localparam int DEPTH         = sigact_pkg::DEPTH;
   localparam int TABLE_ENTRIES = sigact_pkg::TABLE_ENTRIES;

   localparam int LATENCY     = 4;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [ACT_W-1:0]   activation;
      logic [VALUE_W-1:0] gradient;
      logic               error;
   } sig_output_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_command = 1'b0;
   logic [INDEX_W-1:0]        req_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic [ACT_W-1:0]          rsp_activation;
   logic signed [VALUE_W-1:0] rsp_gradient;
   logic                      rsp_error;

   // interpolation points and the shadow of the unit's cache
   logic [31:0]      sig_points [0:TABLE_ENTRIES];
   logic [ACT_W-1:0] cached_y   [0:DEPTH-1];
   bit               y_valid    [0:DEPTH-1];
   sig_output_type   pending_outputs [$];

   // stimulus-side view of what has been written
   logic [INDEX_W-1:0] recent_fwd [$];
   bit                 idling_on;

   int fail_count;
   int stall_cycles = 0;
   int fwd_seen;
   int bwd_seen;
   int err_seen;
   int items_sent;

   sigmoid_activation_fwd_bwd_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_activation (rsp_activation),
      .rsp_gradient   (rsp_gradient),
      .rsp_error      (rsp_error)
   );

   always #2 clock = ~clock;

   // sigmoid sample at x = -8 + 16*k/TABLE_ENTRIES, built in Q31, returned in Q0.16
   function automatic logic [31:0] sample_point(input int unsigned k);
      longint unsigned twok;
      longint unsigned d;
      longint unsigned g;
      longint unsigned term;
      longint unsigned e;
      longint unsigned num;
      longint unsigned den;
      longint unsigned y;
      longint          acc;
      twok = 2 * longint'(k);
      d    = (twok >= TABLE_ENTRIES) ? twok - TABLE_ENTRIES : TABLE_ENTRIES - twok;
      g    = (d << 30) / TABLE_ENTRIES;
      acc  = longint'(1) << 31;
      term = 64'd1 << 31;
      for (int i = 1; i <= 12; i++) begin
         term = ((term * g) >> 31) / longint'(i);
         if (i % 2 == 1)
            acc = acc - longint'(term);
         else
            acc = acc + longint'(term);
      end
      e = (acc < 0) ? 64'd0 : longint'(acc);
      if (e > (64'd1 << 31))
         e = 64'd1 << 31;
      // raise exp(-|x|/16) to the 16th power
      for (int i = 0; i < 4; i++)
         e = (e * e + (64'd1 << 30)) >> 31;
      den = (64'd1 << 31) + e;
      num = (twok >= TABLE_ENTRIES) ? (64'd1 << 31) : e;
      y   = (num * 64'd65536 + den / 2) / den;
      return (y > 64'd65535) ? 32'd65535 : y[31:0];
   endfunction

   function automatic logic [ACT_W-1:0] sigmoid_of(input logic [VALUE_W-1:0] raw);
      longint unsigned u;
      longint unsigned p;
      longint unsigned s;
      longint unsigned f;
      longint unsigned y;
      u = {48'd0, raw ^ 16'h8000};
      if (u == 0)
         return '0;
      p = u * TABLE_ENTRIES;
      s = p >> 16;
      f = p & 64'hFFFF;
      if (s >= TABLE_ENTRIES)
         s = TABLE_ENTRIES - 1;
      y = (64'(sig_points[s]) * (64'd65536 - f) + 64'(sig_points[s + 1]) * f
           + 64'd32768) >> 16;
      return (y > 64'd65535) ? 16'hFFFF : y[15:0];
   endfunction

   // g*y*(1-y), rounded half away from zero on the magnitude
   function automatic logic [VALUE_W-1:0] input_gradient(input logic [VALUE_W-1:0] raw,
                                                         input logic [ACT_W-1:0] y);
      longint unsigned mag;
      longint unsigned yy;
      longint unsigned p;
      longint unsigned r;
      mag = raw[15] ? (64'h10000 - 64'(raw)) : 64'(raw);
      yy  = 64'(y);
      p   = mag * (yy * (64'd65536 - yy));
      r   = (p + (64'd1 << 31)) >> 32;
      return raw[15] ? (16'd0 - r[15:0]) : r[15:0];
   endfunction

   task automatic check_field(input string name, input logic [15:0] expected,
                              input logic [15:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
         fail_count++;
      end
   endtask

   // check results, then predict for the transfer taken at this edge
   always @(posedge clock) begin
      sig_output_type want;
      sig_output_type got;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: result with nothing expected, actual act %h grad %h err %b",
                     $time, rsp_activation, rsp_gradient, rsp_error);
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            got.activation = rsp_activation;
            got.gradient   = rsp_gradient;
            got.error      = rsp_error;
            check_field("activation", want.activation, got.activation);
            check_field("gradient", want.gradient, got.gradient);
            check_field("error", 16'(want.error), 16'(got.error));
         end
      end
      if (reset === 1'b0 && start === 1'b1 && busy === 1'b0) begin
         want.activation = '0;
         want.gradient   = '0;
         want.error      = 1'b0;
         if (req_command == sigact_pkg::CMD_FWD) begin
            want.activation     = sigmoid_of(req_value);
            cached_y[req_index] = want.activation;
            y_valid[req_index]  = 1'b1;
            fwd_seen++;
         end else begin
            bwd_seen++;
            if (!y_valid[req_index]) begin
               want.error = 1'b1;
               err_seen++;
            end else begin
               want.gradient = input_gradient(req_value, cached_y[req_index]);
            end
         end
         pending_outputs.push_back(want);
      end
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("[sigmoid_activation_fwd_bwd_top] ERROR");
      $finish;
   end

   task automatic send_item(input sigact_pkg::cmd_type cmd, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val);
      int gap;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap   = $urandom_range(1, 12);
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       = 1'b1;
      req_command = cmd;
      req_index   = idx;
      req_value   = val;
      if (cmd == sigact_pkg::CMD_FWD) begin
         recent_fwd.push_back(idx);
         if (recent_fwd.size() > 16)
            void'(recent_fwd.pop_front());
      end
      // hold until the transfer
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_outputs.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(0, 3)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_item();
      int                 r;
      logic [INDEX_W-1:0] idx;
      r = $urandom_range(0, 99);
      if (r < 40 || recent_fwd.size() == 0) begin
         // a narrow index range packs writes and reads close together
         idx = (r < 15) ? INDEX_W'($urandom_range(0, 31)) : INDEX_W'($urandom);
         send_item(sigact_pkg::CMD_FWD, idx, random_value());
      end else if (r < 90) begin
         idx = recent_fwd[$urandom_range(0, recent_fwd.size() - 1)];
         send_item(sigact_pkg::CMD_BWD, idx, random_value());
      end else begin
         send_item(sigact_pkg::CMD_BWD, INDEX_W'($urandom), random_value());
      end
   endtask

   task automatic test_unwritten_backward();
      send_item(sigact_pkg::CMD_BWD, 10'd0, 16'h7FFF);
      send_item(sigact_pkg::CMD_BWD, 10'd1023, 16'h8000);
   endtask

   task automatic test_forward_extremes();
      send_item(sigact_pkg::CMD_FWD, 10'd0, 16'h8000);
      send_item(sigact_pkg::CMD_FWD, 10'd1023, 16'h7FFF);
      send_item(sigact_pkg::CMD_FWD, 10'd1, 16'h0000);
      send_item(sigact_pkg::CMD_FWD, 10'd2, 16'hFFFF);
      send_item(sigact_pkg::CMD_FWD, 10'd3, 16'h0001);
      send_item(sigact_pkg::CMD_FWD, 10'd4, 16'h7000);
      send_item(sigact_pkg::CMD_FWD, 10'd5, 16'h9000);
      send_item(sigact_pkg::CMD_FWD, 10'd6, 16'h8001);
   endtask

   task automatic test_backward_extremes();
      send_item(sigact_pkg::CMD_BWD, 10'd0, 16'h7FFF);
      send_item(sigact_pkg::CMD_BWD, 10'd1023, 16'h8000);
      send_item(sigact_pkg::CMD_BWD, 10'd1, 16'h7FFF);
      send_item(sigact_pkg::CMD_BWD, 10'd1, 16'h8000);
      send_item(sigact_pkg::CMD_BWD, 10'd2, 16'h0000);
      send_item(sigact_pkg::CMD_BWD, 10'd3, 16'hFFFF);
   endtask

   // reads that chase a write still in flight
   task automatic test_cache_forwarding();
      idling_on = 1'b0;
      send_item(sigact_pkg::CMD_FWD, 10'd7, random_value());
      send_item(sigact_pkg::CMD_BWD, 10'd7, random_value());
      send_item(sigact_pkg::CMD_FWD, 10'd8, random_value());
      send_item(sigact_pkg::CMD_FWD, 10'd9, random_value());
      send_item(sigact_pkg::CMD_BWD, 10'd8, random_value());
      send_item(sigact_pkg::CMD_FWD, 10'd13, random_value());
      send_item(sigact_pkg::CMD_FWD, 10'd13, random_value());
      send_item(sigact_pkg::CMD_BWD, 10'd13, random_value());
      idling_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int count);
      idling_on = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2)
            wait_for_drain();
         random_item();
      end
   endtask

   task automatic test_full_rate(input int count);
      idling_on = 1'b0;
      for (int n = 0; n < count; n++)
         random_item();
   endtask

   initial begin
      fail_count = 0;
      fwd_seen   = 0;
      bwd_seen   = 0;
      err_seen   = 0;
      items_sent = 0;
      idling_on  = 1'b1;
      for (int k = 0; k <= TABLE_ENTRIES; k++)
         sig_points[k] = sample_point(k);
      for (int i = 0; i < DEPTH; i++)
         y_valid[i] = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_unwritten_backward();
      test_forward_extremes();
      test_backward_extremes();
      test_cache_forwarding();
      test_random_traffic(600);
      test_full_rate(80);

      wait_for_drain();
      repeat (2 * LATENCY) @(negedge clock);

      $display("Sent %0d items: %0d forward, %0d backward (%0d on unwritten entries),",
               items_sent, fwd_seen, bwd_seen, err_seen);
      $display("with idle bursts, one full drain and a closing stretch at full rate.");
      if (fail_count == 0)
         $display("[sigmoid_activation_fwd_bwd_top] OK");
      else
         $display("[sigmoid_activation_fwd_bwd_top] ERROR");
      $finish;
   end

endmodule
